// File: hw/rtl/ipv4_cidr_text_parser_assert.svh
// Assertion macros used by the parser RTL in icp_parse.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef IPV4_CIDR_TEXT_PARSER_ASSERT_SVH
`define IPV4_CIDR_TEXT_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ICP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ICP_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`else

`define ICP_ASSERT(label, prop, msg)
`define ICP_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

// File: hw/rtl/icp_pkg.sv
package icp_pkg;

	// Character codes
	localparam logic [7:0] ChSpace  = 8'd32;
	localparam logic [7:0] ChTab    = 8'd9;
	localparam logic [7:0] ChCr     = 8'd13;
	localparam logic [7:0] ChDot    = 8'd46;
	localparam logic [7:0] ChSlash  = 8'd47;
	localparam logic [7:0] ChZero   = 8'd48;
	localparam logic [7:0] ChNine   = 8'd57;
	localparam logic [7:0] ChUpperA = 8'd65;
	localparam logic [7:0] ChUpperZ = 8'd90;
	localparam logic [7:0] ChLowerA = 8'd97;
	localparam logic [7:0] ChLowerL = 8'd108;
	localparam logic [7:0] CaseFold = 8'd32;

	// Limits and saturation values
	localparam logic [8:0]  OctetMax   = 9'd255;
	localparam logic [8:0]  OctetSat   = 9'd256;
	localparam logic [5:0]  PrefixMax  = 6'd32;
	localparam logic [5:0]  PrefixSat  = 6'd33;
	localparam logic [1:0]  KeywordLen = 2'd3;
	localparam logic [1:0]  LastOctet  = 2'd3;
	localparam logic [31:0] MaskOnes   = 32'hFFFF_FFFF;

	// Parse mode register codes
	localparam logic ModeCidr  = 1'b0;
	localparam logic ModePlain = 1'b1;

	typedef enum logic [2:0] {
		PhLead,
		PhOctet,
		PhPstart,
		PhPrefix,
		PhWord,
		PhTrail
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       string_end;
	} in_word_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] network;
		logic [31:0] mask;
		logic [5:0]  prefix_length;
	} out_word_t;

	// Held input word handed to the parser
	typedef struct packed {
		logic     valid;
		in_word_t word;
	} in_slot_t;

	// Result handed to the output register
	typedef struct packed {
		logic      push;
		out_word_t word;
	} result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == ChSpace) || (c >= ChTab && c <= ChCr);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		return (c >= ChUpperA && c <= ChUpperZ) ? c + CaseFold : c;
	endfunction

	function automatic logic [31:0] mask_of(input logic [5:0] p);
		logic [5:0] pc;
		logic [5:0] sh;
		pc = (p > PrefixMax) ? PrefixMax : p;
		sh = PrefixMax - pc;
		return (p == 6'd0) ? 32'd0 : (MaskOnes << sh);
	endfunction

endpackage

// File: hw/rtl/icp_in_stage.sv
module icp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  icp_pkg::in_word_t  in_word,
	input  logic               advance,
	output icp_pkg::in_slot_t  slot
);

	logic              valid_s1;
	icp_pkg::in_word_t word_s1;

	// Take a new word when the slot is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.word  = word_s1;

endmodule

// File: hw/rtl/icp_parse.sv
`include "ipv4_cidr_text_parser_assert.svh"

module icp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  icp_pkg::in_slot_t  slot,
	input  logic               out_free,
	output logic               advance,
	output icp_pkg::result_t   res
);

	icp_pkg::phase_t phase_q, phase_n;
	logic [1:0]      idx_q, idx_n;
	logic [8:0]      oct_q, oct_n;
	logic            seen_q, seen_n;
	logic            lz_q, lz_n;
	logic [31:0]     addr_q, addr_n;
	logic [5:0]      pfx_q, pfx_n;
	logic [1:0]      kp_q, kp_n;
	logic            error_q, error_n;
	logic            mode_q;

	logic [7:0]  c;
	logic [7:0]  lc;
	logic [3:0]  d;
	logic        blank;
	logic        digit;
	logic        cidr;
	logic        addr_done;
	logic [11:0] oct_calc;
	logic [8:0]  pfx_calc;
	logic [31:0] addr_commit;
	logic        take;
	logic        is_end;

	logic        r_ok;
	logic [31:0] r_addr;
	logic [5:0]  r_pfx;
	logic [31:0] r_mask;

	// Decode the held character
	assign c           = slot.word.char_code;
	assign lc          = icp_pkg::fold_lower(c);
	assign d           = c[3:0];
	assign blank       = icp_pkg::is_blank(c);
	assign digit       = icp_pkg::is_digit(c);
	assign cidr        = (mode_q == icp_pkg::ModeCidr);
	assign addr_done   = (idx_q == icp_pkg::LastOctet) && seen_q;
	assign oct_calc    = {oct_q, 3'b000} + {2'b00, oct_q, 1'b0} + {8'd0, d};
	assign pfx_calc    = {pfx_q, 3'b000} + {2'b00, pfx_q, 1'b0} + {5'd0, d};
	assign addr_commit = {addr_q[23:0], oct_q[7:0]};

	// Advance unless an end word waits for the output register
	assign is_end  = slot.word.string_end;
	assign advance = slot.valid && (!is_end || out_free);
	assign take    = advance && !is_end && !error_q;

	// Next parse state for one character
	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		oct_n   = oct_q;
		seen_n  = seen_q;
		lz_n    = lz_q;
		addr_n  = addr_q;
		pfx_n   = pfx_q;
		kp_n    = kp_q;
		error_n = error_q;
		if (advance && is_end) begin
			phase_n = icp_pkg::PhLead;
			idx_n   = '0;
			oct_n   = '0;
			seen_n  = 1'b0;
			lz_n    = 1'b0;
			addr_n  = '0;
			pfx_n   = '0;
			kp_n    = '0;
			error_n = 1'b0;
		end else if (take) begin
			unique case (phase_q)
				icp_pkg::PhLead, icp_pkg::PhOctet: begin
					if (digit) begin
						phase_n = icp_pkg::PhOctet;
						if (lz_q) begin
							error_n = 1'b1;
						end else begin
							if (!seen_q && d == 4'd0) begin
								lz_n = 1'b1;
							end
							seen_n = 1'b1;
							if (oct_calc > 12'(icp_pkg::OctetMax)) begin
								oct_n   = icp_pkg::OctetSat;
								error_n = 1'b1;
							end else begin
								oct_n = oct_calc[8:0];
							end
						end
					end else if (phase_q == icp_pkg::PhLead) begin
						if (cidr && lc == icp_pkg::ChLowerA) begin
							phase_n = icp_pkg::PhWord;
							kp_n    = 2'd1;
						end else if (!blank) begin
							error_n = 1'b1;
						end
					end else if (c == icp_pkg::ChDot && seen_q
							&& idx_q != icp_pkg::LastOctet) begin
						addr_n = addr_commit;
						oct_n  = '0;
						seen_n = 1'b0;
						lz_n   = 1'b0;
						idx_n  = idx_q + 2'd1;
					end else if (c == icp_pkg::ChSlash && cidr && addr_done) begin
						addr_n  = addr_commit;
						oct_n   = '0;
						seen_n  = 1'b0;
						lz_n    = 1'b0;
						phase_n = icp_pkg::PhPstart;
					end else if (blank && addr_done) begin
						addr_n  = addr_commit;
						oct_n   = '0;
						seen_n  = 1'b0;
						lz_n    = 1'b0;
						pfx_n   = icp_pkg::PrefixMax;
						phase_n = icp_pkg::PhTrail;
					end else begin
						error_n = 1'b1;
					end
				end
				icp_pkg::PhPstart, icp_pkg::PhPrefix: begin
					if (digit) begin
						phase_n = icp_pkg::PhPrefix;
						if (pfx_calc > 9'(icp_pkg::PrefixMax)) begin
							pfx_n   = icp_pkg::PrefixSat;
							error_n = 1'b1;
						end else begin
							pfx_n = pfx_calc[5:0];
						end
					end else if (phase_q == icp_pkg::PhPrefix && blank) begin
						phase_n = icp_pkg::PhTrail;
					end else begin
						error_n = 1'b1;
					end
				end
				icp_pkg::PhWord: begin
					if (kp_q != icp_pkg::KeywordLen) begin
						if (lc == icp_pkg::ChLowerL) begin
							kp_n = kp_q + 2'd1;
						end else begin
							error_n = 1'b1;
						end
					end else if (blank) begin
						pfx_n   = '0;
						phase_n = icp_pkg::PhTrail;
					end else begin
						error_n = 1'b1;
					end
				end
				icp_pkg::PhTrail: begin
					if (!blank) begin
						error_n = 1'b1;
					end
				end
				default: begin
					error_n = 1'b1;
				end
			endcase
		end
	end

	// Judge the string at its end word
	always_comb begin
		r_ok   = 1'b0;
		r_addr = '0;
		r_pfx  = '0;
		if (!error_q) begin
			if (phase_q == icp_pkg::PhOctet && addr_done) begin
				r_ok   = 1'b1;
				r_addr = addr_commit;
				r_pfx  = icp_pkg::PrefixMax;
			end else if (phase_q == icp_pkg::PhPrefix) begin
				r_ok   = cidr;
				r_addr = addr_q;
				r_pfx  = pfx_q;
			end else if (phase_q == icp_pkg::PhWord && kp_q == icp_pkg::KeywordLen) begin
				r_ok = cidr;
			end else if (phase_q == icp_pkg::PhTrail) begin
				r_ok   = (cidr || kp_q == 2'd0) && (cidr || pfx_q == icp_pkg::PrefixMax);
				r_addr = (kp_q != 2'd0) ? 32'd0 : addr_q;
				r_pfx  = pfx_q;
			end
		end
	end

	assign r_mask = icp_pkg::mask_of(r_pfx);

	// Build the result word; zero it unless well formed
	always_comb begin
		res.push               = slot.valid && is_end && out_free;
		res.word.ok            = r_ok;
		res.word.network       = r_ok ? (r_addr & r_mask) : 32'd0;
		res.word.mask          = r_ok ? r_mask : 32'd0;
		res.word.prefix_length = r_ok ? r_pfx : 6'd0;
	end

	// Hold parse state and the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= icp_pkg::PhLead;
			idx_q   <= '0;
			oct_q   <= '0;
			seen_q  <= 1'b0;
			lz_q    <= 1'b0;
			addr_q  <= '0;
			pfx_q   <= '0;
			kp_q    <= '0;
			error_q <= 1'b0;
			mode_q  <= icp_pkg::ModeCidr;
		end else begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			oct_q   <= oct_n;
			seen_q  <= seen_n;
			lz_q    <= lz_n;
			addr_q  <= addr_n;
			pfx_q   <= pfx_n;
			kp_q    <= kp_n;
			error_q <= error_n;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
		end
	end

	`ICP_ASSERT(a_push_on_end, res.push |-> (slot.valid && slot.word.string_end), "result without end word")
	`ICP_ASSERT_NEXT(a_clear_after_end, advance && is_end, phase_q == icp_pkg::PhLead && !error_q && idx_q == 2'd0 && kp_q == 2'd0, "parse state not cleared after end word")
	`ICP_ASSERT(a_fail_zero, (res.push && !res.word.ok) |-> (res.word.mask == 32'd0 && res.word.network == 32'd0 && res.word.prefix_length == 6'd0), "failed result not zeroed")
	`ICP_ASSERT(a_ok_prefix, (res.push && res.word.ok) |-> (res.word.prefix_length <= icp_pkg::PrefixMax), "prefix out of range on good result")
	`ICP_ASSERT(a_octet_sat, 1'b1 |-> (oct_q <= icp_pkg::OctetSat && pfx_q <= icp_pkg::PrefixSat), "accumulator above saturation")

endmodule

// File: hw/rtl/icp_out_stage.sv
module icp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  icp_pkg::result_t   res,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_ready,
	output icp_pkg::out_word_t out_word
);

	logic               valid_q;
	icp_pkg::out_word_t word_q;

	// Free when empty or when the held word leaves this cycle
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (res.push) begin
			word_q <= res.word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// File: hw/rtl/ipv4_cidr_text_parser.sv
// IPv4 dotted-decimal / CIDR text parser.
// Input channel (in_valid/in_ready/in_word): one character word per cycle,
// then a word with string_end set; char_code is ignored on that word.
// Output channel (out_valid/out_ready/out_word): one result word per end
// word with ok, network, mask and prefix_length; all zero when not ok.
// Configuration: cfg_we writes cfg_wdata into the parse mode (0 = CIDR with
// /prefix and the keyword all, 1 = plain address); reset value is CIDR.
// Throughput: one word per cycle unless an end word waits; the parse
// update is combinational between the input and result registers.
// Result: the end word is registered in the input register, and out_valid
// rises when the result register loads from the input register.
// Stall: character words keep flowing while a result waits; an end word
// holds in the input register until the result register frees, and
// in_ready drops while it holds.
// Reset: clears the parse state, empties both registers, sets CIDR mode.
module ipv4_cidr_text_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  icp_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output icp_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	icp_pkg::in_slot_t slot;
	icp_pkg::result_t  res;
	logic              advance;
	logic              out_free;

	icp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.advance  (advance),
		.slot     (slot)
	);

	icp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.slot      (slot),
		.out_free  (out_free),
		.advance   (advance),
		.res       (res)
	);

	icp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// File: test/ipv4_cidr_text_parser_checker.sv
module ipv4_cidr_text_parser_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  icp_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_ready,
	input  icp_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output int unsigned        fail_count,
	output int unsigned        owed,
	output int unsigned        checked,
	output int unsigned        ok_seen
);
	import icp_pkg::*;

	// Parse state as seen by the predictor
	typedef struct packed {
		phase_t      ph;
		logic [1:0]  octet_idx;
		logic [8:0]  octet_acc;
		logic        have_digit;
		logic        zero_lead;
		logic [31:0] addr_acc;
		logic [5:0]  pfx_acc;
		logic [1:0]  kw_pos;
		logic        bad;
	} parse_t;

	parse_t      text_st;
	logic        mode;
	out_word_t   due_results[$];
	out_word_t   want;
	int unsigned errors;
	int unsigned n_checked;
	int unsigned n_ok;

	function automatic logic blank_char(input logic [7:0] c);
		return (c == ChSpace) || (c >= ChTab && c <= ChCr);
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

	// Add one digit to the octet; reject a digit after a leading zero
	function automatic parse_t take_octet_digit(input parse_t s, input int d);
		int v;
		if (s.zero_lead) begin
			s.bad = 1'b1;
			return s;
		end
		if (!s.have_digit && d == 0)
			s.zero_lead = 1'b1;
		s.have_digit = 1'b1;
		v = int'(s.octet_acc) * 10 + d;
		if (v > 255) begin
			s.octet_acc = OctetSat;
			s.bad = 1'b1;
		end else begin
			s.octet_acc = v[8:0];
		end
		return s;
	endfunction

	// Shift the finished octet into the address
	function automatic parse_t close_octet(input parse_t s);
		s.addr_acc = {s.addr_acc[23:0], s.octet_acc[7:0]};
		s.octet_acc = '0;
		s.have_digit = 1'b0;
		s.zero_lead = 1'b0;
		return s;
	endfunction

	// Advance the parse by one character
	function automatic parse_t parse_char(input parse_t s, input logic [7:0] c,
		input logic cidr);
		logic [7:0] lc;
		logic       full;
		int         pv;
		lc = (c >= ChUpperA && c <= ChUpperZ) ? c + CaseFold : c;
		full = (s.octet_idx == LastOctet) && s.have_digit;
		if (s.bad)
			return s;
		case (s.ph)
			PhLead: begin
				if (blank_char(c)) begin
				end else if (digit_char(c)) begin
					s.ph = PhOctet;
					s = take_octet_digit(s, int'(c) - int'(ChZero));
				end else if (cidr && lc == ChLowerA) begin
					s.ph = PhWord;
					s.kw_pos = 2'd1;
				end else begin
					s.bad = 1'b1;
				end
			end
			PhOctet: begin
				if (digit_char(c)) begin
					s = take_octet_digit(s, int'(c) - int'(ChZero));
				end else if (c == ChDot && s.have_digit && s.octet_idx < LastOctet) begin
					s = close_octet(s);
					s.octet_idx = s.octet_idx + 2'd1;
				end else if (c == ChSlash && cidr && full) begin
					s = close_octet(s);
					s.ph = PhPstart;
				end else if (blank_char(c) && full) begin
					s = close_octet(s);
					s.pfx_acc = PrefixMax;
					s.ph = PhTrail;
				end else begin
					s.bad = 1'b1;
				end
			end
			PhPstart, PhPrefix: begin
				if (digit_char(c)) begin
					pv = int'(s.pfx_acc) * 10 + int'(c) - int'(ChZero);
					if (pv > 32) begin
						s.pfx_acc = PrefixSat;
						s.bad = 1'b1;
					end else begin
						s.pfx_acc = pv[5:0];
					end
					s.ph = PhPrefix;
				end else if (s.ph == PhPrefix && blank_char(c)) begin
					s.ph = PhTrail;
				end else begin
					s.bad = 1'b1;
				end
			end
			PhWord: begin
				if (s.kw_pos < KeywordLen) begin
					if (lc == ChLowerL)
						s.kw_pos = s.kw_pos + 2'd1;
					else
						s.bad = 1'b1;
				end else if (blank_char(c)) begin
					s.pfx_acc = '0;
					s.ph = PhTrail;
				end else begin
					s.bad = 1'b1;
				end
			end
			PhTrail: begin
				if (!blank_char(c))
					s.bad = 1'b1;
			end
			default: s.bad = 1'b1;
		endcase
		return s;
	endfunction

	// Judge the whole string at its end word
	function automatic out_word_t finish_text(input parse_t s, input logic plain);
		out_word_t   r;
		logic        good;
		logic [31:0] a;
		logic [5:0]  p;
		logic [31:0] m;
		good = 1'b0;
		a = '0;
		p = '0;
		if (!s.bad) begin
			if (s.ph == PhOctet && s.octet_idx == LastOctet && s.have_digit) begin
				good = 1'b1;
				a = {s.addr_acc[23:0], s.octet_acc[7:0]};
				p = PrefixMax;
			end else if (s.ph == PhPrefix) begin
				good = !plain;
				a = s.addr_acc;
				p = s.pfx_acc;
			end else if (s.ph == PhWord && s.kw_pos == KeywordLen) begin
				good = !plain;
			end else if (s.ph == PhTrail) begin
				good = !plain || s.kw_pos == 2'd0;
				if (plain && s.pfx_acc != PrefixMax)
					good = 1'b0;
				a = (s.kw_pos != 2'd0) ? 32'd0 : s.addr_acc;
				p = s.pfx_acc;
			end
		end
		m = (p == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (32 - int'(p)));
		r.ok = good;
		r.network = good ? (a & m) : 32'd0;
		r.mask = good ? m : 32'd0;
		r.prefix_length = good ? p : 6'd0;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		if (errors < 30)
			$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// Track config, predict on each input word, compare each output word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = ModeCidr;
			text_st = '0;
			due_results.delete();
			errors = 0;
			n_checked = 0;
			n_ok = 0;
		end else begin
			if (cfg_we)
				mode = cfg_wdata;
			if (in_valid && in_ready) begin
				if (!in_word.string_end) begin
					text_st = parse_char(text_st, in_word.char_code, mode == ModeCidr);
				end else begin
					due_results.push_back(finish_text(text_st, mode == ModePlain));
					text_st = '0;
				end
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					flag_error("result word with none expected");
				end else begin
					want = due_results.pop_front();
					if (out_word.ok !== want.ok)
						flag_error($sformatf("ok %0b, expected %0b", out_word.ok, want.ok));
					if (out_word.network !== want.network)
						flag_error($sformatf("network %h, expected %h",
							out_word.network, want.network));
					if (out_word.mask !== want.mask)
						flag_error($sformatf("mask %h, expected %h", out_word.mask, want.mask));
					if (out_word.prefix_length !== want.prefix_length)
						flag_error($sformatf("prefix_length %0d, expected %0d",
							out_word.prefix_length, want.prefix_length));
					n_checked++;
					if (want.ok)
						n_ok++;
				end
			end
		end
		fail_count <= errors;
		owed <= due_results.size();
		checked <= n_checked;
		ok_seen <= n_ok;
	end

endmodule

// File: test/tb_ipv4_cidr_text_parser.sv
module tb_ipv4_cidr_text_parser;
	import icp_pkg::*;

	localparam int PhaseCount    = 6;
	localparam int PhaseWords    = 185;
	localparam int SettleCycles  = 4;
	localparam int WatchdogLimit = 500;
	localparam logic [7:0] ChPlus  = "+";
	localparam logic [7:0] ChMinus = "-";

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        cfg_we;
	logic        cfg_wdata;

	int unsigned fail_count;
	int unsigned owed;
	int unsigned checked;
	int unsigned ok_seen;

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet = 0;
	int unsigned words_sent = 0;
	int unsigned strings_sent = 0;
	logic        cur_mode = ModeCidr;
	logic        carry_open = 1'b0;
	logic [7:0]  line_q[$];

	int   idle_plan[PhaseCount]  = '{0, 50, 0, 28, 28, 0};
	int   stall_plan[PhaseCount] = '{0, 0, 50, 28, 28, 0};
	logic mode_plan[PhaseCount]  = '{ModeCidr, ModePlain, ModeCidr, ModePlain, ModeCidr,
		ModePlain};

	ipv4_cidr_text_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ipv4_cidr_text_parser_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.owed       (owed),
		.checked    (checked),
		.ok_seen    (ok_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WatchdogLimit) begin
			$display("timeout: no word moved for %0d cycles", quiet);
			$display("FAIL");
			$finish;
		end
	end

	// Offer one word, idling first at random, and hold until taken
	task automatic send_word(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{char_code: c, string_end: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// Send the queued characters, then the end word if asked
	task automatic send_line(input logic close);
		foreach (line_q[i])
			send_word(line_q[i], 1'b0);
		if (close) begin
			send_word(8'($urandom_range(255)), 1'b1);
			strings_sent++;
		end
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic put_blanks(input int n);
		repeat (n)
			line_q.push_back(($urandom_range(5) == 5) ? ChTab + 8'($urandom_range(4)) : ChSpace);
	endtask

	function automatic int pick_octet();
		case ($urandom_range(5))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Build a string well formed in CIDR mode: address, address/prefix or the keyword
	task automatic build_good();
		int p;
		line_q.delete();
		put_blanks($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
		if ($urandom_range(9) == 0) begin
			line_q.push_back($urandom_range(1) ? ChLowerA : ChUpperA);
			repeat (2)
				line_q.push_back($urandom_range(1) ? ChLowerL : ChLowerL - CaseFold);
		end else begin
			put_text($sformatf("%0d.%0d.%0d.%0d", pick_octet(), pick_octet(), pick_octet(),
				pick_octet()));
			if ($urandom_range(cur_mode == ModePlain ? 4 : 1) == 0) begin
				line_q.push_back(ChSlash);
				case ($urandom_range(3))
					0: p = 0;
					1: p = 32;
					default: p = $urandom_range(32);
				endcase
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(1, 2))
						line_q.push_back(ChZero);
				put_text($sformatf("%0d", p));
			end
		end
		put_blanks($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
	endtask

	// Spoil the queued string in one place
	task automatic break_line();
		int pos;
		pos = (line_q.size() == 0) ? 0 : $urandom_range(line_q.size() - 1);
		case ($urandom_range(6))
			0: if (line_q.size() != 0) line_q[pos] = 8'($urandom_range(255));
			1: line_q.insert(pos, 8'($urandom_range(255)));
			2: if (line_q.size() != 0) line_q.delete(pos);
			3: begin
				case ($urandom_range(2))
					0: line_q.insert(pos, ChPlus);
					1: line_q.insert(pos, ChMinus);
					default: line_q.insert(pos, ChSpace);
				endcase
			end
			4: while (line_q.size() > pos) line_q.pop_back();
			5: line_q.insert(pos, ChZero + 8'($urandom_range(9)));
			default: begin
				line_q.push_back(ChDot);
				put_text($sformatf("%0d", $urandom_range(999)));
			end
		endcase
	endtask

	task automatic build_noise();
		line_q.delete();
		repeat ($urandom_range(6))
			line_q.push_back(8'($urandom_range(255)));
	endtask

	// Drain the block, then let it go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (SettleCycles)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
	endtask

	initial begin
		int phase_start;
		int cut;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PhaseCount; ph++) begin
			settle();
			write_mode(mode_plan[ph]);
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			phase_start = words_sent;

			// Directed: top octet and prefix, keyword with mixed case, empty, leading zero
			if (ph == 0) begin
				line_q.delete();
				put_text("9.0.0.255/32");
				send_line(1'b1);
				line_q.delete();
				put_text("All");
				line_q.push_back(ChTab);
				send_line(1'b1);
				line_q.delete();
				send_line(1'b1);
				put_text("01");
				send_line(1'b1);
			end

			// Finish the string left open across the mode change
			if (carry_open) begin
				send_line(1'b1);
				carry_open = 1'b0;
			end

			while (words_sent - phase_start < PhaseWords) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: build_good();
					6, 7, 8: begin
						build_good();
						break_line();
					end
					default: build_noise();
				endcase
				send_line(1'b1);
			end

			// Leave a string half sent before the next mode write
			if (ph < PhaseCount - 1 && $urandom_range(1) == 0) begin
				build_good();
				cut = $urandom_range(line_q.size());
				for (int i = 0; i < cut; i++)
					send_word(line_q[i], 1'b0);
				repeat (cut)
					line_q.pop_front();
				carry_open = 1'b1;
			end
		end

		settle();
		$display("covered %0d words in %0d strings over %0d phases in both parse modes",
			words_sent, strings_sent, PhaseCount);
		$display("%0d results checked, %0d of them well formed", checked, ok_seen);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
